@@ hdl/iir_bp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_bp_pkg
// Shared constants and controller/datapath interface types for the band-pass
// biquad.
// ----------------------------------------------------------------------------
package iir_bp_pkg;

	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int COEF_FRAC_BITS_DEF = 30;
	localparam int GAIN_FRAC_BITS     = 28;
	localparam int COEF_W             = 32;
	localparam int CFG_IDX_W          = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 3'd3;

	localparam logic signed [COEF_W-1:0] GAIN_RESET = 32'sd268435456;

	typedef enum logic [2:0] {
		MUL_DIFF_ALPHA,
		MUL_Y1_GAMMA,
		MUL_Y2_BETA,
		MUL_ACCLO_GAIN,
		MUL_ACCHI_GAIN
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     save_lo;
		logic     combine;
		logic     finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

@@ hdl/iir_bp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_bp_ctrl
// Sequencer that steps the shared multiplier through the five products of
// one sample, then rounds and writes the result.
// ----------------------------------------------------------------------------
module iir_bp_ctrl
	import iir_bp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_G,
		ST_MUL_B,
		ST_ACC,
		ST_GAIN_LO,
		ST_GAIN_HI,
		ST_COMBINE,
		ST_ROUND
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:    if (in_valid) state_q <= ST_MUL_A;
				ST_MUL_A:   state_q <= ST_MUL_G;
				ST_MUL_G:   state_q <= ST_MUL_B;
				ST_MUL_B:   state_q <= ST_ACC;
				ST_ACC:     state_q <= ST_GAIN_LO;
				ST_GAIN_LO: state_q <= ST_GAIN_HI;
				ST_GAIN_HI: state_q <= ST_COMBINE;
				ST_COMBINE: state_q <= ST_ROUND;
				ST_ROUND:   if (!status.out_busy) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_DIFF_ALPHA;
		cmd.acc_op  = ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DIFF_ALPHA;
			end
			ST_MUL_G: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Y1_GAMMA;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_MUL_B: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Y2_BETA;
				cmd.acc_op  = ACC_ADD;
			end
			ST_ACC: begin
				cmd.acc_op = ACC_SUB;
			end
			ST_GAIN_LO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ACCLO_GAIN;
			end
			ST_GAIN_HI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ACCHI_GAIN;
				cmd.save_lo = 1'b1;
			end
			ST_COMBINE: begin
				cmd.combine = 1'b1;
			end
			ST_ROUND: begin
				cmd.finish = !status.out_busy;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule

@@ hdl/iir_bp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_bp_datapath
// Coefficient registers, delay line, shared multiplier, accumulator, gain
// product assembly, rounding/saturation and the output register.
// ----------------------------------------------------------------------------
module iir_bp_datapath
	import iir_bp_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [COEF_W-1:0]            cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  dp_cmd_t                      cmd,
	output dp_status_t                   status,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                         saturated
);

	localparam int DIFF_W   = SAMPLE_BITS + 1;
	localparam int ACC_W    = SAMPLE_BITS + 35;
	localparam int HI_W     = ACC_W - 32;
	localparam int MUL_A_W  = (SAMPLE_BITS + 3 > 33) ? SAMPLE_BITS + 3 : 33;
	localparam int MUL_P_W  = MUL_A_W + COEF_W;
	localparam int PW       = ACC_W + 32;
	localparam int SHIFT    = COEF_FRAC_BITS + GAIN_FRAC_BITS - 1;
	localparam int RW       = PW + 1 - SHIFT;

	localparam logic signed [SAMPLE_BITS-1:0] YMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] YMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [PW:0]            HALF = (PW+1)'(1) <<< (SHIFT - 1);

	logic signed [COEF_W-1:0]      alpha_q, beta_q, gamma_q, gain_q;
	logic signed [SAMPLE_BITS-1:0] xd1_q, xd2_q, yd1_q, yd2_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [DIFF_W-1:0]      diff_q;
	logic signed [MUL_P_W-1:0]     prod_s1;
	logic signed [MUL_P_W-1:0]     plo_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [PW-1:0]          full_q;
	logic                          out_valid_q;

	logic signed [MUL_A_W-1:0]     mul_a;
	logic signed [COEF_W-1:0]      mul_b;
	logic signed [ACC_W-1:0]       prod_acc;
	logic signed [PW-1:0]          full_d;
	logic signed [PW:0]            rnd_sum;
	logic signed [RW-1:0]          rnd_res;
	logic signed [SAMPLE_BITS-1:0] y_d;
	logic                          sat_d;

	assign status.out_busy = out_valid_q && !out_ready;
	assign out_valid       = out_valid_q;

	// operand selection for the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MUL_DIFF_ALPHA: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = alpha_q;
			end
			MUL_Y1_GAMMA: begin
				mul_a = MUL_A_W'(yd1_q);
				mul_b = gamma_q;
			end
			MUL_Y2_BETA: begin
				mul_a = MUL_A_W'(yd2_q);
				mul_b = beta_q;
			end
			MUL_ACCLO_GAIN: begin
				mul_a = $signed({{(MUL_A_W-32){1'b0}}, acc_q[31:0]});
				mul_b = gain_q;
			end
			MUL_ACCHI_GAIN: begin
				mul_a = MUL_A_W'($signed(acc_q[ACC_W-1:32]));
				mul_b = gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_acc = ACC_W'(prod_s1);

	// gain product: high partial weighted by 2^32 plus unsigned-low partial
	assign full_d = $signed({prod_s1[HI_W+COEF_W-1:0], 32'd0}) + PW'(plo_q);

	// round half up, then clamp to the sample range
	assign rnd_sum = (PW+1)'(full_q) + HALF;
	assign rnd_res = $signed(rnd_sum[PW:SHIFT]);

	always_comb begin
		if (rnd_res > RW'(YMAX)) begin
			y_d   = YMAX;
			sat_d = 1'b1;
		end else if (rnd_res < RW'(YMIN)) begin
			y_d   = YMIN;
			sat_d = 1'b1;
		end else begin
			y_d   = SAMPLE_BITS'(rnd_res);
			sat_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= '0;
			beta_q      <= '0;
			gamma_q     <= '0;
			gain_q      <= GAIN_RESET;
			xd1_q       <= '0;
			xd2_q       <= '0;
			yd1_q       <= '0;
			yd2_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHA: alpha_q <= cfg_data;
					REG_BETA:  beta_q  <= cfg_data;
					REG_GAMMA: gamma_q <= cfg_data;
					REG_GAIN:  gain_q  <= cfg_data;
					default:   alpha_q <= alpha_q;
				endcase
			end
			if (cmd.finish) begin
				xd2_q <= xd1_q;
				xd1_q <= x_q;
				yd2_q <= yd1_q;
				yd1_q <= y_d;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= sample_in;
			diff_q <= DIFF_W'(sample_in) - DIFF_W'(xd2_q);
		end
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
		end
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_acc;
			ACC_ADD:  acc_q <= acc_q + prod_acc;
			ACC_SUB:  acc_q <= acc_q - prod_acc;
			default:  acc_q <= acc_q;
		endcase
		if (cmd.save_lo) begin
			plo_q <= prod_s1;
		end
		if (cmd.combine) begin
			full_q <= full_d;
		end
		if (cmd.finish) begin
			sample_out <= y_d;
			saturated  <= sat_d;
		end
	end

endmodule

@@ hdl/iir_bandpass_biquad.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_bandpass_biquad
// Second-order band-pass equalizer band with saturating 24-bit output.
// ----------------------------------------------------------------------------
// Each input word is one signed sample; each output word is the filtered
// sample y = 2*gain*(alpha*(x - x[n-2]) + gamma*y[n-1] - beta*y[n-2]), rounded
// half up and clamped to the sample range, with tuser high when it clipped.
// Each accepted sample is stepped to the output register by a sequencer:
// a single shared multiplier forms the three coefficient products and the two
// halves of the gain product in turn, followed by a combine and a round step.
// The next sample is taken in the cycle after that sequence ends, so a new
// sample is never accepted before the last one is through, while the previous
// result may still wait in the output register; the round step waits only if
// that register still holds an untaken word. Coefficient writes take effect at
// once and belong between samples.
module iir_bandpass_biquad
	import iir_bp_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
	localparam int TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [TDATA_W-1:0]   s_axis_tdata,   // sample_in
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TDATA_W-1:0]   m_axis_tdata,   // sample_out
	output logic                 m_axis_tuser    // saturated
);

	dp_cmd_t                      cmd;
	dp_status_t                   status;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                         saturated;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = TDATA_W'($unsigned(sample_out));
	assign m_axis_tuser = saturated;

	iir_bp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	iir_bp_datapath #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_in  ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.sample_out (sample_out),
		.saturated  (saturated)
	);

endmodule

@@ sim/iir_bandpass_biquad_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_bandpass_biquad_tb
// Self-checking bench for the band-pass biquad with saturating output.
// ----------------------------------------------------------------------------
// A bit-exact filter predictor runs beside the block and keeps its own delay
// line and coefficient copy. Every output word is checked against the oldest
// prediction. Stimulus starts with directed cases: reset coefficients,
// rounding ties, clipping at both ends, extreme and negative gain, and writes
// to unused register indexes. Random phases with fresh coefficient sets follow.
// Both stream sides idle in random bursts, and the output side holds off
// once for a long stretch. The bench also waits for the pipeline to drain
// before any coefficient write.
module iir_bandpass_biquad_tb;
	import iir_bp_pkg::*;

	localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
	localparam int TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;
	localparam int ROUND_SHIFT  = COEF_FRAC_BITS_DEF + GAIN_FRAC_BITS - 1;
	localparam int RANDOM_ITEMS = 1900;
	localparam int QUIET_ITEMS  = 300;
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 20;

	localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (ROUND_SHIFT - 1);
	localparam logic signed [127:0] Y_MAX      = (128'sd1 <<< (SAMPLE_W - 1)) - 128'sd1;
	localparam logic signed [127:0] Y_MIN      = -(128'sd1 <<< (SAMPLE_W - 1));

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_GAIN + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = {CFG_IDX_W{1'b1}};

	localparam logic [COEF_W-1:0] Q30_QUARTER = 32'h1000_0000;
	localparam logic [COEF_W-1:0] Q30_HALF    = 32'h2000_0000;
	localparam logic [COEF_W-1:0] Q28_ONE     = 32'h1000_0000;
	localparam logic [COEF_W-1:0] COEF_POS    = 32'h7fff_ffff;
	localparam logic [COEF_W-1:0] COEF_NEG    = 32'h8000_0000;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                clip;
	} band_result_t;

	typedef logic [CFG_IDX_W-1:0] reg_index_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]    cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [TDATA_W-1:0]   s_axis_tdata = '0;   // sample_in
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]   m_axis_tdata;        // sample_out
	logic                 m_axis_tuser;        // saturated

	// predictor state
	logic signed [COEF_W-1:0]   coef_alpha_q = '0;
	logic signed [COEF_W-1:0]   coef_beta_q  = '0;
	logic signed [COEF_W-1:0]   coef_gamma_q = '0;
	logic signed [COEF_W-1:0]   band_gain_q  = GAIN_RESET;
	logic signed [SAMPLE_W-1:0] x_dly1 = '0;
	logic signed [SAMPLE_W-1:0] x_dly2 = '0;
	logic signed [SAMPLE_W-1:0] y_dly1 = '0;
	logic signed [SAMPLE_W-1:0] y_dly2 = '0;

	logic [SAMPLE_W-1:0] sample_backlog[$];
	band_result_t        expected_band[$];
	band_result_t        want;

	int   issued = 0;
	int   results_seen = 0;
	int   mismatches = 0;
	int   send_gap = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	logic in_fire = 1'b0;
	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;

	iir_bandpass_biquad u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// exact sum and gain product, then round half up and clamp
	function automatic band_result_t filter_sample(input logic signed [SAMPLE_W-1:0] x);
		logic signed [127:0] acc;
		logic signed [127:0] prod;
		logic signed [127:0] rounded;
		band_result_t        r;
		acc = (x - x_dly2) * coef_alpha_q + y_dly1 * coef_gamma_q - y_dly2 * coef_beta_q;
		prod = acc * band_gain_q;
		rounded = (prod + ROUND_HALF) >>> ROUND_SHIFT;
		r.clip = 1'b0;
		if (rounded > Y_MAX) begin
			r.sample = SAMPLE_MAX;
			r.clip = 1'b1;
		end else if (rounded < Y_MIN) begin
			r.sample = SAMPLE_MIN;
			r.clip = 1'b1;
		end else begin
			r.sample = rounded[SAMPLE_W-1:0];
		end
		x_dly2 = x_dly1;
		x_dly1 = x;
		y_dly2 = y_dly1;
		y_dly1 = $signed(r.sample);
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SAMPLE_W'($urandom_range(0, 64) - 32);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] extreme_coef();
		case ($urandom_range(0, 4))
			0: return COEF_NEG;
			1: return COEF_POS;
			2: return '0;
			3: return 32'h0000_0001;
			default: return '1;
		endcase
	endfunction

	// call at a falling edge; returns at a falling edge with cfg_valid still high
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic load_coefs(input logic [COEF_W-1:0] alpha, input logic [COEF_W-1:0] beta,
			input logic [COEF_W-1:0] gamma, input logic [COEF_W-1:0] gain);
		if ($urandom_range(0, 3) == 0)
			write_reg(reg_index_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_BETA, beta);
		write_reg(REG_GAMMA, gamma);
		write_reg(REG_GAIN, gain);
		// an unused index must leave the coefficients alone
		if ($urandom_range(0, 2) == 0)
			write_reg(reg_index_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
		cfg_valid <= 1'b0;
	endtask

	task automatic feed(input logic [SAMPLE_W-1:0] s);
		sample_backlog.push_back(s);
		issued++;
	endtask

	task automatic drain();
		while (results_seen < issued) @(negedge clk);
	endtask

	// sample driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (sample_backlog.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= TDATA_W'(sample_backlog.pop_front());
				if (!quiet && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 11);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output side backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 10);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor: coefficient copy, prediction and checking
	always @(posedge clk) begin
		in_fire <= s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ALPHA: coef_alpha_q = cfg_data;
					REG_BETA:  coef_beta_q = cfg_data;
					REG_GAMMA: coef_gamma_q = cfg_data;
					REG_GAIN:  band_gain_q = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_band.push_back(filter_sample(s_axis_tdata[SAMPLE_W-1:0]));
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (expected_band.size() == 0) begin
					$error("output word with no sample pending: sample_out %0d",
						$signed(m_axis_tdata[SAMPLE_W-1:0]));
					mismatches++;
				end else begin
					want = expected_band.pop_front();
					if (m_axis_tdata[SAMPLE_W-1:0] !== want.sample) begin
						$error("sample_out: expected %0d, got %0d", $signed(want.sample),
							$signed(m_axis_tdata[SAMPLE_W-1:0]));
						mismatches++;
					end
					if (m_axis_tuser !== want.clip) begin
						$error("saturated: expected %0b, got %0b", want.clip, m_axis_tuser);
						mismatches++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
					(m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("iir_bandpass_biquad regression: fail");
		$finish;
	end

	initial begin
		int goal;
		int n_items;
		int phase;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset coefficients: alpha is zero so every output is zero
		feed(SAMPLE_MAX);
		feed(SAMPLE_MIN);
		feed(random_sample());
		drain();

		// y = (x - x[n-2]) / 2, so odd differences land on a tie
		load_coefs(Q30_QUARTER, '0, '0, Q28_ONE);
		feed(SAMPLE_W'(1));
		feed('1);
		feed('0);
		feed(SAMPLE_W'(2));
		feed(SAMPLE_W'(-3));
		feed(SAMPLE_W'(-2));
		drain();

		// clipping at both ends with the largest positive gain
		load_coefs(COEF_POS, COEF_POS, COEF_NEG, COEF_POS);
		feed(SAMPLE_MAX);
		feed(SAMPLE_MIN);
		feed(SAMPLE_MAX);
		feed(SAMPLE_MIN);
		feed('0);
		feed('0);
		drain();

		// most negative gain, alpha and beta, with the largest positive gamma
		load_coefs(COEF_NEG, COEF_NEG, COEF_POS, COEF_NEG);
		feed(SAMPLE_MIN);
		feed(SAMPLE_MAX);
		feed(SAMPLE_W'(1));
		feed('1);
		feed('0);
		drain();

		// plain difference x - x[n-2] at unity gain
		load_coefs(Q30_HALF, '0, '0, Q28_ONE);
		feed(SAMPLE_MAX);
		feed(SAMPLE_MIN);
		feed(SAMPLE_MIN);
		feed(SAMPLE_MAX);
		drain();

		goal = issued + RANDOM_ITEMS;
		phase = 0;
		while (issued < goal) begin
			case ($urandom_range(0, 3))
				0: load_coefs($urandom(), $urandom(), $urandom(), $urandom());
				1: load_coefs($urandom_range(0, 32'h1000_0000),
					$urandom_range(32'h3000_0000, 32'h3fff_ffff),
					$urandom_range(32'h6000_0000, 32'h7fff_ffff),
					$urandom_range(0, 32'h4000_0000));
				2: load_coefs(extreme_coef(), extreme_coef(), extreme_coef(), extreme_coef());
				default: load_coefs($urandom_range(0, 32'h1000_0000) - 32'h0800_0000,
					$urandom_range(0, 32'h4000_0000) - 32'h2000_0000,
					$urandom_range(0, 32'h4000_0000) - 32'h2000_0000,
					$urandom_range(0, 32'h2000_0000));
			endcase
			if (phase == 2)
				hold_req = 1'b1;
			if (goal - issued <= QUIET_ITEMS)
				quiet = 1'b1;
			n_items = $urandom_range(80, 220);
			if (n_items > goal - issued)
				n_items = goal - issued;
			repeat (n_items) feed(random_sample());
			drain();
			phase++;
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_band.size() != 0) begin
			$error("%0d predicted samples never came out", expected_band.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("iir_bandpass_biquad regression: pass");
		else
			$display("iir_bandpass_biquad regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/iir_bp_pkg.sv
hdl/iir_bp_ctrl.sv
hdl/iir_bp_datapath.sv
hdl/iir_bandpass_biquad.sv
sim/iir_bandpass_biquad_tb.sv
